@@ hdl/kruskal_union_find_edge_filter_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef KRUSKAL_UNION_FIND_EDGE_FILTER_MACROS_SVH
`define KRUSKAL_UNION_FIND_EDGE_FILTER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define KUF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define KUF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/kuf_pkg.sv @@
package kuf_pkg;

  localparam int NODES_DEF = 256;
  localparam int EDGES_DEF = 4096;

  localparam int NODE_W   = 8;
  localparam int WEIGHT_W = 16;
  localparam int NUM_W    = 12;
  localparam int POS_W    = 8;
  localparam int COST_W   = 32;

  localparam logic signed [COST_W+1:0] COST_MAX = 34'sd2147483647;
  localparam logic signed [COST_W+1:0] COST_MIN = -34'sd2147483648;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK_A,
    ST_WALK_B,
    ST_FIN
  } kuf_state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic walk_a;
    logic walk_b;
    logic finish;
  } kuf_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_range;
    logic at_root;
    logic out_free;
  } kuf_stat_t;

endpackage

@@ hdl/kuf_if.sv @@
interface kuf_edge_if;
  import kuf_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       new_graph;
  logic        [NODE_W-1:0]   orig_node;
  logic        [NODE_W-1:0]   dest_node;
  logic signed [WEIGHT_W-1:0] edge_weight;

  modport source (output valid, new_graph, orig_node, dest_node, edge_weight, input ready);
  modport sink   (input valid, new_graph, orig_node, dest_node, edge_weight, output ready);
endinterface

interface kuf_result_if;
  import kuf_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     accepted;
  logic        [NUM_W-1:0]  edge_number;
  logic        [POS_W-1:0]  tree_position;
  logic signed [COST_W-1:0] tree_cost;

  modport source (output valid, accepted, edge_number, tree_position, tree_cost, input ready);
  modport sink   (input valid, accepted, edge_number, tree_position, tree_cost, output ready);
endinterface

@@ hdl/kuf_ctrl.sv @@
module kuf_ctrl import kuf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  kuf_stat_t stat_i,
  output kuf_cmd_t  cmd_o
);

  kuf_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_WALK_A;
        end
      end
      ST_WALK_A: begin
        if (!stat_i.in_range) begin
          state_d = ST_FIN;
        end else begin
          cmd_o.walk_a = 1'b1;
          if (stat_i.at_root) state_d = ST_WALK_B;
        end
      end
      ST_WALK_B: begin
        cmd_o.walk_b = 1'b1;
        if (stat_i.at_root) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

@@ hdl/kuf_datapath.sv @@
module kuf_datapath import kuf_pkg::*; #(
  parameter int NODES = NODES_DEF,
  parameter int EDGES = EDGES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  kuf_cmd_t                   cmd_i,
  output kuf_stat_t                  stat_o,
  input  logic                       new_graph_i,
  input  logic        [NODE_W-1:0]   orig_node_i,
  input  logic        [NODE_W-1:0]   dest_node_i,
  input  logic signed [WEIGHT_W-1:0] edge_weight_i,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output logic                       accepted_o,
  output logic        [NUM_W-1:0]    edge_number_o,
  output logic        [POS_W-1:0]    tree_position_o,
  output logic signed [COST_W-1:0]   tree_cost_o
);

  // Node fields are 8 bits, so at most 256 table entries are reachable.
  localparam int TBL = (NODES < (1 << NODE_W)) ? NODES : (1 << NODE_W);
  localparam int IW  = $clog2(TBL);
  localparam int EW  = $clog2(EDGES);

  logic [IW-1:0] mem [TBL];
  logic [IW-1:0] rd_q;
  logic [TBL-1:0] vld_q;

  logic [IW-1:0] cur_q, ra_q, b_q;
  logic [IW-1:0] up, rd_addr;
  logic          in_range_q;
  logic signed [WEIGHT_W-1:0] w_q;

  logic [EW-1:0]   seen_q, number_q, base;
  logic [POS_W-1:0] tree_q, slot_q;
  logic signed [COST_W-1:0] cost_q;
  logic signed [COST_W+1:0] sum;
  logic          take_q;
  logic          at_root, link;
  logic          out_valid_q;

  assign up      = vld_q[cur_q] ? rd_q : cur_q;
  assign at_root = (up == cur_q);
  assign link    = cmd_i.walk_b && at_root && (ra_q != cur_q);

  assign stat_o.in_range = in_range_q;
  assign stat_o.at_root  = at_root;
  assign stat_o.out_free = !out_valid_q || res_ready_i;

  always_comb begin
    priority if (cmd_i.load) begin
      rd_addr = orig_node_i[IW-1:0];
    end else if (cmd_i.walk_a && at_root) begin
      rd_addr = b_q;
    end else begin
      rd_addr = up;
    end
  end

  assign base = new_graph_i ? '0 : seen_q;
  assign sum  = (COST_W+2)'(cost_q) + (COST_W+2)'(w_q);

  always_ff @(posedge clk_i) begin
    if (link) mem[ra_q] <= cur_q;
    rd_q <= mem[rd_addr];
  end

  // Walk and payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_q      <= orig_node_i[IW-1:0];
      b_q        <= dest_node_i[IW-1:0];
      w_q        <= edge_weight_i;
      in_range_q <= (32'(orig_node_i) < 32'(NODES)) && (32'(dest_node_i) < 32'(NODES));
      number_q   <= base;
    end else if (cmd_i.walk_a) begin
      cur_q <= at_root ? b_q : up;
      if (at_root) ra_q <= cur_q;
    end else if (cmd_i.walk_b) begin
      cur_q <= up;
    end
    if (link) slot_q <= tree_q;
  end

  // Graph state: valid bits, counters, cost.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      seen_q <= '0;
      tree_q <= '0;
      cost_q <= '0;
      take_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        seen_q <= (32'(base) + 32'd1 >= 32'(EDGES)) ? '0 : base + EW'(1);
        take_q <= 1'b0;
        if (new_graph_i) begin
          vld_q  <= '0;
          tree_q <= '0;
          cost_q <= '0;
        end
      end
      if (link) begin
        vld_q[ra_q] <= 1'b1;
        tree_q      <= tree_q + POS_W'(1);
        take_q      <= 1'b1;
        if (sum > COST_MAX) begin
          cost_q <= COST_MAX[COST_W-1:0];
        end else if (sum < COST_MIN) begin
          cost_q <= COST_MIN[COST_W-1:0];
        end else begin
          cost_q <= sum[COST_W-1:0];
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      accepted_o      <= take_q;
      edge_number_o   <= NUM_W'(number_q);
      tree_position_o <= take_q ? slot_q : '0;
      tree_cost_o     <= cost_q;
    end
  end

  assign res_valid_o = out_valid_q;

endmodule

@@ hdl/kruskal_union_find_edge_filter.sv @@
// Kruskal edge filter with a union-find parent table.
// edge_i (sink): one edge per transaction, sorted by ascending weight, with
//   new_graph, orig_node, dest_node and a signed 16-bit edge_weight.
// result_o (source): one transaction per edge with accepted, edge_number,
//   tree_position (zero when rejected) and the saturating tree_cost.
// Each end is walked to its root one parent link per cycle through a
// registered-read table; the parent-table read port sets the pace. Only one
// edge is in flight: the next edge is taken once the controller is back in
// idle after handing off the result. An edge with an end outside the table
// skips both walks and goes straight to the hand-off.
// new_graph restores the table through per-entry valid bits, so no clearing
// pass is needed after reset either.
// Reset clears the valid bits, counters and cost; the block is ready at once.
// The result sits in an output register: the next edge is taken while it
// waits, and a finished edge holds in the controller until the register
// frees up, which back-pressures edge_i.
module kruskal_union_find_edge_filter import kuf_pkg::*; #(
  parameter int NODES = NODES_DEF,
  parameter int EDGES = EDGES_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  kuf_edge_if.sink     edge_i,
  kuf_result_if.source result_o
);

  kuf_cmd_t  cmd;
  kuf_stat_t stat;

  // Sequencer: idle, walk first end, walk second end and link, hand off.
  kuf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (edge_i.valid),
    .in_ready_o (edge_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Parent table, walk registers, counters, cost and the result register.
  kuf_datapath #(
    .NODES (NODES),
    .EDGES (EDGES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .new_graph_i     (edge_i.new_graph),
    .orig_node_i     (edge_i.orig_node),
    .dest_node_i     (edge_i.dest_node),
    .edge_weight_i   (edge_i.edge_weight),
    .res_valid_o     (result_o.valid),
    .res_ready_i     (result_o.ready),
    .accepted_o      (result_o.accepted),
    .edge_number_o   (result_o.edge_number),
    .tree_position_o (result_o.tree_position),
    .tree_cost_o     (result_o.tree_cost)
  );

endmodule

@@ hdl/kuf_checker.sv @@
`include "kruskal_union_find_edge_filter_macros.svh"

module kuf_checker import kuf_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic              accepted_i,
  input logic [POS_W-1:0]  tree_position_i
);

  // one edge in flight: ready is low once an edge has been taken
  `KUF_ASSERT_NEXT(a_one_in_flight, in_valid_i && in_ready_i, !in_ready_i, "edge taken back to back")
  // a rejected edge reports slot zero
  `KUF_ASSERT_NOW(a_reject_slot, out_valid_i && !accepted_i, tree_position_i == '0, "rejected edge has slot")
  // a result is not dropped while stalled
  `KUF_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result dropped")

endmodule

bind kruskal_union_find_edge_filter kuf_checker u_kuf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (edge_i.valid),
  .in_ready_i      (edge_i.ready),
  .out_valid_i     (result_o.valid),
  .out_ready_i     (result_o.ready),
  .accepted_i      (result_o.accepted),
  .tree_position_i (result_o.tree_position)
);

@@ bench/kruskal_union_find_edge_filter_tb.sv @@
`timescale 1ns / 1ps

module kruskal_union_find_edge_filter_tb;
  import kuf_pkg::*;

  localparam int NODES        = NODES_DEF;
  localparam int EDGES        = EDGES_DEF;
  localparam int MAX_GAP      = 12;
  localparam int RANDOM_EDGES = 720;

  typedef struct {
    logic                       new_graph;
    logic        [NODE_W-1:0]   orig_node;
    logic        [NODE_W-1:0]   dest_node;
    logic signed [WEIGHT_W-1:0] edge_weight;
    bit                         drain;      // hold off until every result is back
  } edge_item_t;

  typedef struct packed {
    logic                     accepted;
    logic        [NUM_W-1:0]  edge_number;
    logic        [POS_W-1:0]  tree_position;
    logic signed [COST_W-1:0] tree_cost;
  } edge_result_t;

  // result-side ready patterns
  typedef enum int {
    RX_OPEN,
    RX_BUSY,
    RX_CHOKED
  } rx_mode_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  kuf_edge_if   edge_bus ();
  kuf_result_if result_bus ();

  kruskal_union_find_edge_filter #(
    .NODES (NODES),
    .EDGES (EDGES)
  ) dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .edge_i   (edge_bus),
    .result_o (result_bus)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Union-find predictor: its own parent table, counters and running cost.
  // No path compression, so the walks match what the block sees.
  // ---------------------------------------------------------------------
  logic        [NODE_W-1:0] parent_tbl [NODES];
  logic        [NUM_W-1:0]  edge_count;
  logic        [POS_W-1:0]  slot_count;
  logic signed [COST_W-1:0] cost_sum;

  function automatic void clear_forest();
    int k;
    for (k = 0; k < NODES; k++) parent_tbl[k] = NODE_W'(k);
    edge_count = '0;
    slot_count = '0;
    cost_sum   = '0;
  endfunction

  function automatic logic [NODE_W-1:0] find_root(logic [NODE_W-1:0] node);
    int                steps;
    logic [NODE_W-1:0] up;
    for (steps = 0; steps < NODES; steps++) begin
      up = parent_tbl[node];
      if (up == node) break;
      node = up;
    end
    return node;
  endfunction

  function automatic edge_result_t filter_edge(edge_item_t e);
    edge_result_t      r;
    logic [NODE_W-1:0] ra;
    logic [NODE_W-1:0] rb;
    longint            sum;
    if (e.new_graph) clear_forest();
    r.accepted      = 1'b0;
    r.edge_number   = edge_count;
    r.tree_position = '0;
    edge_count = (edge_count == NUM_W'(EDGES - 1)) ? '0 : edge_count + 1'b1;
    // ends outside the table only bump the edge counter
    if (int'(e.orig_node) < NODES && int'(e.dest_node) < NODES) begin
      ra = find_root(e.orig_node);
      rb = find_root(e.dest_node);
      if (ra != rb) begin
        parent_tbl[ra]  = rb;
        r.accepted      = 1'b1;
        r.tree_position = slot_count;
        slot_count      = slot_count + 1'b1;
        sum = longint'(cost_sum) + longint'(e.edge_weight);
        if (sum > COST_MAX) sum = COST_MAX;
        else if (sum < COST_MIN) sum = COST_MIN;
        cost_sum = COST_W'(sum);
      end
    end
    r.tree_cost = cost_sum;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------
  edge_item_t   pending_edges    [$];
  edge_result_t expected_results [$];

  function automatic void add_edge(bit ng, int a, int b, int w, bit drain = 1'b0);
    edge_item_t e;
    e.new_graph   = ng;
    e.orig_node   = NODE_W'(a);
    e.dest_node   = NODE_W'(b);
    e.edge_weight = WEIGHT_W'(w);
    e.drain       = drain;
    pending_edges.push_back(e);
  endfunction

  // Well-formed graph: new_graph on the first edge, ends from a node window
  // (tight windows give many cycles and rejects), weights mostly ascending.
  function automatic void random_graph(int n_edges);
    int k;
    int span;
    int base;
    int w;
    bit sorted;
    case ($urandom_range(0, 2))
      0:       span = $urandom_range(2, 8);
      1:       span = $urandom_range(9, 48);
      default: span = NODES;
    endcase
    base   = $urandom_range(0, NODES - span);
    sorted = ($urandom_range(0, 9) != 0);
    w      = $urandom_range(0, 50000) - 32768;
    for (k = 0; k < n_edges; k++) begin
      if (sorted) w = (w + 300 > 32767) ? 32767 : w + $urandom_range(0, 300);
      else w = $urandom_range(0, 65535) - 32768;
      add_edge(k == 0, base + $urandom_range(0, span - 1), base + $urandom_range(0, span - 1),
               w, k == 0 && $urandom_range(0, 3) == 0);
    end
  endfunction

  // Linear chain 0->1->...->len-1, then queries that walk most of it.
  function automatic void chain_graph(int len);
    int k;
    int w;
    w = $urandom_range(0, 1000) - 32768;
    for (k = 0; k < len - 1; k++) add_edge(k == 0, k, k + 1, w + k, k == 0);
    add_edge(1'b0, 0, 0, w + len, 1'b0);    // self loop at the deepest leaf
    for (k = 0; k < 10; k++)
      add_edge(1'b0, $urandom_range(0, len / 4), $urandom_range(0, len - 1),
               w + len + k, 1'b0);
  endfunction

  // ---------------------------------------------------------------------
  // Driver: pops pending edges, bursts with random gaps in between.
  // An edge marked drain waits until every predicted result has come back.
  // ---------------------------------------------------------------------
  edge_item_t edge_on_bus;
  int         burst_left;
  int         gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_bus.valid       <= 1'b0;
      edge_bus.new_graph   <= 1'b0;
      edge_bus.orig_node   <= '0;
      edge_bus.dest_node   <= '0;
      edge_bus.edge_weight <= '0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      // transaction taken: predict its result now
      if (edge_bus.valid && edge_bus.ready)
        expected_results.push_back(filter_edge(edge_on_bus));
      if (!edge_bus.valid || edge_bus.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          edge_bus.valid <= 1'b0;
        end else if (pending_edges.size() == 0 ||
                     (pending_edges[0].drain && expected_results.size() != 0)) begin
          edge_bus.valid <= 1'b0;
        end else begin
          edge_on_bus = pending_edges.pop_front();
          edge_bus.valid       <= 1'b1;
          edge_bus.new_graph   <= edge_on_bus.new_graph;
          edge_bus.orig_node   <= edge_on_bus.orig_node;
          edge_bus.dest_node   <= edge_on_bus.dest_node;
          edge_bus.edge_weight <= edge_on_bus.edge_weight;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 48);
            // a quarter of the bursts run straight into the next one
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_GAP);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: checks each result transaction against the oldest prediction,
  // ready follows one of the rx_mode patterns, redrawn whenever mode_left runs out.
  // ---------------------------------------------------------------------
  rx_mode_e     rx_mode;
  int           mode_left;
  int           results_seen;
  int           mismatches;
  edge_result_t got;
  edge_result_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_bus.ready <= 1'b0;
      rx_mode   = RX_OPEN;
      mode_left = 0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        got.accepted      = result_bus.accepted;
        got.edge_number   = result_bus.edge_number;
        got.tree_position = result_bus.tree_position;
        got.tree_cost     = result_bus.tree_cost;
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("t=%0t unexpected result acc=%0b num=%0d pos=%0d cost=%0d", $realtime,
                     got.accepted, got.edge_number, got.tree_position, got.tree_cost);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $write("t=%0t result %0d: expected acc=%0b num=%0d pos=%0d cost=%0d, ",
                     $realtime, results_seen - 1, want.accepted, want.edge_number,
                     want.tree_position, want.tree_cost);
              $display("got acc=%0b num=%0d pos=%0d cost=%0d", got.accepted,
                       got.edge_number, got.tree_position, got.tree_cost);
            end
          end
        end
      end
      if (mode_left <= 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(16, 400);
      end
      mode_left--;
      case (rx_mode)
        RX_OPEN: result_bus.ready <= 1'b1;
        RX_BUSY: result_bus.ready <= ($urandom_range(0, 3) != 0);
        default: result_bus.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Watchdog
  int unsigned cycle_count;
  int unsigned cycle_limit;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > cycle_limit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Sequence: build the whole stimulus, reset, wait for every result.
  // ---------------------------------------------------------------------
  initial begin
    int total_items;
    int start_size;
    bit long_chain_done;

    edge_bus.valid       = 1'b0;
    edge_bus.new_graph   = 1'b0;
    edge_bus.orig_node   = '0;
    edge_bus.dest_node   = '0;
    edge_bus.edge_weight = '0;
    result_bus.ready     = 1'b0;
    results_seen = 0;
    mismatches   = 0;
    cycle_count  = 0;
    clear_forest();

    // directed: field extremes, self loops, cycles, new graph back to back
    add_edge(1'b1, 0, 255, -32768, 1'b1);
    add_edge(1'b0, 255, 0, -32768);          // same tree, ends swapped
    add_edge(1'b0, 7, 7, -32767);            // self loop
    add_edge(1'b0, 1, 2, -1);
    add_edge(1'b0, 2, 3, 0);
    add_edge(1'b0, 3, 1, 1);                 // closes a cycle
    add_edge(1'b0, 8'h55, 8'hAA, 100);
    add_edge(1'b0, 8'hAA, 8'h55, 200);
    add_edge(1'b0, 1, 255, 300);             // merges two trees
    add_edge(1'b0, 0, 3, 400);               // rejected after longer walks
    add_edge(1'b0, 128, 127, 32767);
    add_edge(1'b0, 127, 128, 32767);
    add_edge(1'b1, 255, 255, 32767, 1'b1);   // new graph on a self loop
    add_edge(1'b1, 0, 1, 5);                 // new graph right after
    add_edge(1'b0, 1, 0, 5);
    add_edge(1'b0, 254, 253, -32768);        // weight out of order

    // random part: mostly graphs, some chains, some noise
    start_size      = pending_edges.size();
    long_chain_done = 1'b0;
    while (pending_edges.size() - start_size < RANDOM_EDGES) begin
      if (!long_chain_done) begin
        chain_graph(NODES);
        long_chain_done = 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
        chain_graph($urandom_range(32, NODES));
      end else if ($urandom_range(0, 5) == 0) begin
        // noise: any field, new_graph at random, may extend the previous graph
        add_edge($urandom_range(0, 1), $urandom_range(0, NODES - 1),
                 $urandom_range(0, NODES - 1), $urandom_range(0, 65535) - 32768);
      end else begin
        random_graph($urandom_range(1, 60));
      end
    end

    total_items = pending_edges.size();
    cycle_limit = total_items * (2 * NODES + 8 + MAX_GAP + 64) * 2 + 20000;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (results_seen < total_items) @(posedge clk_i);
    // catch anything the block might still push out
    repeat (2 * NODES + 16) @(posedge clk_i);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/kuf_pkg.sv
hdl/kuf_if.sv
hdl/kuf_ctrl.sv
hdl/kuf_datapath.sv
hdl/kruskal_union_find_edge_filter.sv
hdl/kuf_checker.sv
bench/kruskal_union_find_edge_filter_tb.sv
